@@ rtl/ramped_sine_oscillator_pan_top_macros.svh @@
// Assertion macros for the oscillator block. Each expects clk and rst_n in scope.
`ifndef RAMPED_SINE_OSCILLATOR_PAN_TOP_MACROS_SVH
`define RAMPED_SINE_OSCILLATOR_PAN_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define RSOP_AST(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rsop assertion failed");

`define RSOP_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsop implication failed");

`define RSOP_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsop next-cycle check failed");

`else

`define RSOP_AST(lbl, cond)
`define RSOP_AST_IMP(lbl, ante, cons)
`define RSOP_AST_NXT(lbl, ante, cons)

`endif

`endif

@@ rtl/rsop_pkg.sv @@
package rsop_pkg;

  localparam int MAX_FRAMES      = 64;
  localparam int FRM_W           = $clog2(MAX_FRAMES + 1);
  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_TBL_SIZE   = 1 << SINE_TABLE_BITS;

  localparam int FREQ_W = 31;
  localparam int AMP_W  = 16;
  localparam int SR_W   = 18;

  localparam logic [AMP_W-1:0]  UNITY_Q15     = 16'd32768;
  localparam logic [FREQ_W-1:0] RST_FREQUENCY = 31'd28835840;
  localparam logic [AMP_W-1:0]  RST_AMPLITUDE = 16'd3277;
  localparam logic [AMP_W-1:0]  RST_PAN       = 16'd16384;
  localparam logic [SR_W-1:0]   RST_SR        = 18'd48000;

  // shared divider: 47-bit dividend (31-bit value << 16), 18-bit divisor
  localparam int DIV_DW = FREQ_W + 16;
  localparam int DIV_SW = SR_W;
  localparam int DIV_CW = $clog2(DIV_DW);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef logic [15:0] sine_tbl_t [SINE_TBL_SIZE];

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SINE_DIV [10] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                             64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  // Q30 Taylor series, evaluated at elaboration only
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / SINE_DIV[n-1];
      if (n % 2 == 1) sum = sum - $signed(term);
      else            sum = sum + $signed(term);
    end
    if (sum < 0) sum = '0;
    return sum;
  endfunction

  function automatic sine_tbl_t build_sine_tbl();
    sine_tbl_t   t;
    logic [63:0] x;
    logic [63:0] v;
    for (int k = 0; k < SINE_TBL_SIZE; k++) begin
      x = HALF_PI_Q30 * (64'(2 * k) + 64'd1) / 64'(2 * SINE_TBL_SIZE);
      v = (sine_q30(x) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      t[k] = v[15:0];
    end
    return t;
  endfunction

endpackage

@@ rtl/rsop_div.sv @@
// restoring divider, one quotient bit per cycle
module rsop_div
  import rsop_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_DW-1:0] dividend,
  input  logic [DIV_SW-1:0] divisor,
  output logic [DIV_DW-1:0] quotient,
  output div_stat_t         stat
);

  logic [DIV_DW-1:0] q_r,   q_nxt;
  logic [DIV_SW-1:0] rem_r, rem_nxt;
  logic [DIV_SW-1:0] dsr_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DIV_SW:0]   rem_sh;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_r, q_r[DIV_DW-1]};
    ge      = rem_sh >= {1'b0, dsr_r};
    rem_nxt = ge ? DIV_SW'(rem_sh - {1'b0, dsr_r}) : rem_sh[DIV_SW-1:0];
    q_nxt   = {q_r[DIV_DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

@@ rtl/ramped_sine_oscillator_pan_top.sv @@
// Channel   Dir  Beat payload                                     Flow
// in_       in   target_frequency, target_amplitude, target_pan,  in_valid / in_stall
//                frame_count
// out_      out  left_sample, right_sample, last_frame            out_valid / out_stall
// cfg_      in   sample_rate (wr_en / wr_data)                    write only
//
// Block setup: three ramp divisions. Each frame then runs the bit-serial
// divider computing the phase step, a sine read and three passes through the
// shared multiplier. Reset is synchronous, active low.
// One block is worked at a time; in_stall stays high until its last beat
// leaves. out_stall only holds the frame in its output registers.
`include "ramped_sine_oscillator_pan_top_macros.svh"
module ramped_sine_oscillator_pan_top
  import rsop_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FREQ_W-1:0]        in_target_frequency,
  input  logic [AMP_W-1:0]         in_target_amplitude,
  input  logic [AMP_W-1:0]         in_target_pan,
  input  logic [FRM_W-1:0]         in_frame_count,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [15:0]       out_left_sample,
  output logic signed [15:0]       out_right_sample,
  output logic                     out_last_frame,
  input  logic                     cfg_wr_en,
  input  logic [SR_W-1:0]          cfg_wr_data
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DIVF = 11'b000_0000_0010,
    S_DIVA = 11'b000_0000_0100,
    S_DIVP = 11'b000_0000_1000,
    S_SIN  = 11'b000_0001_0000,
    S_MUL1 = 11'b000_0010_0000,
    S_MULL = 11'b000_0100_0000,
    S_MULR = 11'b000_1000_0000,
    S_RND  = 11'b001_0000_0000,
    S_DIVS = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  localparam int ACC_W  = DIV_DW + 1;  // signed Q.16 frequency accumulator
  localparam int AACC_W = 33;          // signed Q.16 amplitude / pan accumulator

  // sine quarter-wave ROM, built at elaboration, registered read
  localparam sine_tbl_t SINE_TBL = build_sine_tbl();

  state_t state_r, state_nxt;

  logic [31:0]       phase_r;
  logic [FREQ_W-1:0] cur_f_r;
  logic [AMP_W-1:0]  cur_a_r, cur_p_r;
  logic [SR_W-1:0]   sr_r;

  logic [FREQ_W-1:0] tgt_f_r;
  logic [AMP_W-1:0]  tgt_a_r, tgt_p_r;
  logic [FRM_W-1:0]  n_r, frm_r;

  logic signed [ACC_W-1:0]  acc_f_r, dlt_f_r;
  logic signed [AACC_W-1:0] acc_a_r, acc_p_r, dlt_a_r, dlt_p_r;

  logic [31:0]        step_r;
  logic [30:0]        m1_r;
  logic [46:0]        prod_r;
  logic signed [15:0] left_r, right_r;
  logic               last_r;
  logic               go_r;

  logic [15:0] rom_q_r;
  logic [SINE_TABLE_BITS-1:0] rom_addr;

  // input saturation
  logic [AMP_W-1:0]  in_amp_sat, in_pan_sat;
  logic [FRM_W-1:0]  in_n_sat;

  // divider hookup
  logic [DIV_DW-1:0] div_dvd, div_q;
  logic [DIV_SW-1:0] div_dsr;
  div_stat_t         div_stat;
  logic              div_neg;

  // shared multiplier
  logic [30:0] mul_a;
  logic [15:0] mul_b;
  logic [46:0] mul_p;

  logic [AMP_W-1:0]  amp_now, pan_now;
  logic [FREQ_W-1:0] frq_now;
  logic              in_acc, out_acc;

  function automatic logic signed [15:0] rnd_q30(input logic [46:0] mag, input logic neg);
    logic [16:0] r;
    logic [15:0] s;
    r = 17'((mag + 47'(1 << 29)) >> 30);
    s = (r > 17'd32767) ? 16'd32767 : r[15:0];
    return neg ? -$signed(s) : $signed(s);
  endfunction

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  assign in_amp_sat = (in_target_amplitude > UNITY_Q15) ? UNITY_Q15 : in_target_amplitude;
  assign in_pan_sat = (in_target_pan > UNITY_Q15) ? UNITY_Q15 : in_target_pan;
  assign in_n_sat   = (in_frame_count > FRM_W'(MAX_FRAMES)) ? FRM_W'(MAX_FRAMES)
                                                              : in_frame_count;

  assign frq_now = acc_f_r[DIV_DW-1:16];
  assign amp_now = acc_a_r[31:16];
  assign pan_now = acc_p_r[31:16];

  // quadrant mirror on odd quadrants
  assign rom_addr = phase_r[30] ? ~phase_r[29 -: SINE_TABLE_BITS]
                                : phase_r[29 -: SINE_TABLE_BITS];

  always_ff @(posedge clk) begin
    rom_q_r <= SINE_TBL[rom_addr];
  end

  // divider operands per state
  always_comb begin
    div_dvd = '0;
    div_dsr = DIV_SW'(n_r);
    div_neg = 1'b0;
    unique case (state_r)
      S_DIVF: begin
        div_neg = tgt_f_r < cur_f_r;
        div_dvd = {(div_neg ? cur_f_r - tgt_f_r : tgt_f_r - cur_f_r), 16'b0};
      end
      S_DIVA: begin
        div_neg = tgt_a_r < cur_a_r;
        div_dvd = DIV_DW'({(div_neg ? cur_a_r - tgt_a_r : tgt_a_r - cur_a_r), 16'b0});
      end
      S_DIVP: begin
        div_neg = tgt_p_r < cur_p_r;
        div_dvd = DIV_DW'({(div_neg ? cur_p_r - tgt_p_r : tgt_p_r - cur_p_r), 16'b0});
      end
      S_DIVS: begin
        div_dvd = {frq_now, 16'b0};
        div_dsr = sr_r;
      end
      default: ;
    endcase
  end

  rsop_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go_r),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_comb begin
    mul_a = m1_r;
    mul_b = pan_now;
    unique case (state_r)
      S_MUL1:  begin mul_a = 31'(rom_q_r); mul_b = amp_now; end
      S_MULR:  mul_b = 16'(17'(UNITY_Q15) - 17'(pan_now));
      default: ;
    endcase
    mul_p = 47'(mul_a) * 47'(mul_b);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && in_n_sat != '0) state_nxt = S_DIVF;
      S_DIVF: if (div_stat.done) state_nxt = S_DIVA;
      S_DIVA: if (div_stat.done) state_nxt = S_DIVP;
      S_DIVP: if (div_stat.done) state_nxt = S_SIN;
      S_SIN:  state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MULL;
      S_MULL: state_nxt = S_MULR;
      S_MULR: state_nxt = S_RND;
      S_RND:  state_nxt = S_DIVS;
      S_DIVS: if (div_stat.done) state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = last_r ? S_IDLE : S_SIN;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= '0;
      cur_f_r <= RST_FREQUENCY;
      cur_a_r <= RST_AMPLITUDE;
      cur_p_r <= RST_PAN;
      sr_r    <= RST_SR;
      go_r    <= 1'b0;
      frm_r   <= '0;
    end else begin
      state_r <= state_nxt;
      go_r    <= 1'b0;
      if (cfg_wr_en) sr_r <= cfg_wr_data;
      unique case (state_r)
        S_IDLE: if (in_acc && in_n_sat != '0) begin
          go_r  <= 1'b1;
          frm_r <= '0;
        end
        S_DIVF, S_DIVA: if (div_stat.done) go_r <= 1'b1;
        S_RND:  go_r <= 1'b1;
        S_OUT:  if (!out_stall) begin
          phase_r <= phase_r + step_r;
          frm_r   <= frm_r + 1'b1;
          if (last_r) begin
            cur_f_r <= tgt_f_r;
            cur_a_r <= tgt_a_r;
            cur_p_r <= tgt_p_r;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (in_acc) begin
        tgt_f_r <= in_target_frequency;
        tgt_a_r <= in_amp_sat;
        tgt_p_r <= in_pan_sat;
        n_r     <= in_n_sat;
        acc_f_r <= $signed({1'b0, cur_f_r, 16'b0});
        acc_a_r <= $signed({1'b0, cur_a_r, 16'b0});
        acc_p_r <= $signed({1'b0, cur_p_r, 16'b0});
      end
      S_DIVF: if (div_stat.done)
        dlt_f_r <= div_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
      S_DIVA: if (div_stat.done)
        dlt_a_r <= div_neg ? -$signed({1'b0, div_q[31:0]}) : $signed({1'b0, div_q[31:0]});
      S_DIVP: if (div_stat.done)
        dlt_p_r <= div_neg ? -$signed({1'b0, div_q[31:0]}) : $signed({1'b0, div_q[31:0]});
      S_MUL1: m1_r   <= mul_p[30:0];
      S_MULL: prod_r <= mul_p;
      S_MULR: begin
        left_r <= rnd_q30(prod_r, phase_r[31]);
        prod_r <= mul_p;
      end
      S_RND: begin
        right_r <= rnd_q30(prod_r, phase_r[31]);
        last_r  <= frm_r == n_r - 1'b1;
      end
      S_DIVS: if (div_stat.done) step_r <= (sr_r == '0) ? 32'd0 : div_q[31:0];
      S_OUT: if (!out_stall) begin
        acc_f_r <= acc_f_r + dlt_f_r;
        acc_a_r <= acc_a_r + dlt_a_r;
        acc_p_r <= acc_p_r + dlt_p_r;
      end
      default: ;
    endcase
  end

  assign in_stall         = state_r != S_IDLE;
  assign out_valid        = state_r == S_OUT;
  assign out_left_sample  = left_r;
  assign out_right_sample = right_r;
  assign out_last_frame   = last_r;

  `RSOP_AST_IMP(a_no_in_during_out, out_valid, in_stall)
  `RSOP_AST_NXT(a_last_to_idle, out_acc && out_last_frame, state_r == S_IDLE)
  `RSOP_AST_IMP(a_frame_in_range, state_r != S_IDLE, frm_r < n_r)
  `RSOP_AST_IMP(a_div_start_free, go_r, !div_stat.busy)

endmodule
